### hw/rtl/bdsp_pkg.sv
package bdsp_pkg;

	localparam int SUM_BITS = 32;
	localparam int OUT_BITS = 32;

	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_LF      = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
	localparam logic [7:0] CHAR_RBRACK  = 8'h5D;

	typedef enum logic [1:0] {
		PKT_FIRST,
		PKT_SECOND,
		PKT_BODY,
		PKT_CUT
	} packet_phase_t;

	typedef enum logic [1:0] {
		TERM_SPACE,
		TERM_SIGN,
		TERM_DIGITS,
		TERM_DONE
	} term_phase_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] sum;
		logic                       session_end;
	} result_t;

endpackage

### hw/rtl/bdsp_out_buf.sv
module bdsp_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bdsp_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output bdsp_pkg::result_t out_data
);

	logic [1:0]        count_q;
	logic              rd_ptr_q;
	logic              wr_ptr_q;
	bdsp_pkg::result_t entry_q [2];
	logic              pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

### hw/rtl/bracketed_decimal_sum_parser_unit.sv
// bracketed decimal sum parser unit
// input channel: in_valid / in_ready with data_byte, one raw stream byte per beat
// output channel: out_valid / out_ready with packet_sum and session_end
// a packet such as [12+3+456] yields one result beat when its ']' is taken
// newline bytes are dropped, the first byte of each packet is skipped
// terms are read like strtol in base 10 and summed modulo 2^32
// an empty packet "[]" yields session_end = 1, after which all bytes are dropped
// throughput: one input beat per cycle while the output buffer is not full
// a result is written into the output buffer when its closing beat is taken
// results wait in a two-entry output buffer; in_ready falls only when it is full,
// so a stalled receiver backs up the input after two pending results
// reset: asynchronous, clears the parser state and empties the output buffer;
// in_ready is high right after reset
module bracketed_decimal_sum_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] packet_sum,
	output logic               session_end
);

	localparam int SB = bdsp_pkg::SUM_BITS;

	bdsp_pkg::packet_phase_t pkt_q, pkt_nx;
	bdsp_pkg::term_phase_t   term_q, term_nx;
	logic                    fwb_q, fwb_nx;
	logic                    neg_q, neg_nx;
	logic [SB-1:0]           val_q, val_nx;
	logic [SB-1:0]           sum_q, sum_nx;
	logic                    stop_q, stop_nx;

	logic                    accept;
	logic                    buf_full;
	logic                    res_valid;
	bdsp_pkg::result_t       res;
	bdsp_pkg::result_t       out_data;

	logic                    is_digit;
	logic                    is_space;
	logic [SB-1:0]           digit_val;
	logic [SB-1:0]           term_signed;
	logic [SB-1:0]           sum_closed;
	logic [SB-1:0]           val_times10;

	assign accept = in_valid && in_ready;

	assign is_digit  = (data_byte >= bdsp_pkg::CHAR_ZERO) && (data_byte <= bdsp_pkg::CHAR_NINE);
	assign is_space  = (data_byte == bdsp_pkg::CHAR_SPACE)
		|| ((data_byte >= bdsp_pkg::CHAR_TAB) && (data_byte <= bdsp_pkg::CHAR_CR));
	assign digit_val   = SB'(data_byte - bdsp_pkg::CHAR_ZERO) & SB'(4'hF);
	assign term_signed = neg_q ? (SB'(0) - val_q) : val_q;
	assign sum_closed  = sum_q + term_signed;
	assign val_times10 = (val_q << 3) + (val_q << 1);

	always_comb begin
		pkt_nx    = pkt_q;
		term_nx   = term_q;
		fwb_nx    = fwb_q;
		neg_nx    = neg_q;
		val_nx    = val_q;
		sum_nx    = sum_q;
		stop_nx   = stop_q;
		res_valid = 1'b0;
		res.sum         = '0;
		res.session_end = 1'b0;

		if (!stop_q && (data_byte != bdsp_pkg::CHAR_LF)) begin
			if (data_byte == bdsp_pkg::CHAR_RBRACK) begin
				res_valid = 1'b1;
				if (pkt_q == bdsp_pkg::PKT_FIRST) begin
					res.sum = '0;
				end else if ((pkt_q == bdsp_pkg::PKT_SECOND) && fwb_q) begin
					res.session_end = 1'b1;
					stop_nx         = 1'b1;
				end else begin
					res.sum = OUT_SUM_CAST(sum_closed);
				end
				pkt_nx  = bdsp_pkg::PKT_FIRST;
				fwb_nx  = 1'b0;
				sum_nx  = '0;
				term_nx = bdsp_pkg::TERM_SPACE;
				neg_nx  = 1'b0;
				val_nx  = '0;
			end else if (pkt_q == bdsp_pkg::PKT_FIRST) begin
				fwb_nx = (data_byte == bdsp_pkg::CHAR_LBRACK);
				pkt_nx = bdsp_pkg::PKT_SECOND;
			end else if (pkt_q != bdsp_pkg::PKT_CUT) begin
				pkt_nx = bdsp_pkg::PKT_BODY;
				if ((data_byte == bdsp_pkg::CHAR_NUL) || (data_byte == bdsp_pkg::CHAR_PLUS)) begin
					sum_nx  = sum_closed;
					term_nx = bdsp_pkg::TERM_SPACE;
					neg_nx  = 1'b0;
					val_nx  = '0;
					if (data_byte == bdsp_pkg::CHAR_NUL)
						pkt_nx = bdsp_pkg::PKT_CUT;
				end else begin
					case (term_q)
						bdsp_pkg::TERM_SPACE: begin
							if (is_space) begin
								term_nx = term_q;
							end else if (data_byte == bdsp_pkg::CHAR_MINUS) begin
								neg_nx  = 1'b1;
								term_nx = bdsp_pkg::TERM_SIGN;
							end else if (is_digit) begin
								val_nx  = digit_val;
								term_nx = bdsp_pkg::TERM_DIGITS;
							end else begin
								term_nx = bdsp_pkg::TERM_DONE;
							end
						end
						bdsp_pkg::TERM_SIGN: begin
							if (is_digit) begin
								val_nx  = digit_val;
								term_nx = bdsp_pkg::TERM_DIGITS;
							end else begin
								val_nx  = '0;
								term_nx = bdsp_pkg::TERM_DONE;
							end
						end
						bdsp_pkg::TERM_DIGITS: begin
							if (is_digit)
								val_nx = val_times10 + digit_val;
							else
								term_nx = bdsp_pkg::TERM_DONE;
						end
						default: begin
							term_nx = term_q;
						end
					endcase
				end
			end
		end
	end

	function automatic logic signed [bdsp_pkg::OUT_BITS-1:0] OUT_SUM_CAST(
		input logic [SB-1:0] s
	);
		logic [bdsp_pkg::OUT_BITS-1:0] w;
		w = bdsp_pkg::OUT_BITS'(s);
		return $signed(w);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q  <= bdsp_pkg::PKT_FIRST;
			term_q <= bdsp_pkg::TERM_SPACE;
			fwb_q  <= 1'b0;
			neg_q  <= 1'b0;
			val_q  <= '0;
			sum_q  <= '0;
			stop_q <= 1'b0;
		end else if (accept) begin
			pkt_q  <= pkt_nx;
			term_q <= term_nx;
			fwb_q  <= fwb_nx;
			neg_q  <= neg_nx;
			val_q  <= val_nx;
			sum_q  <= sum_nx;
			stop_q <= stop_nx;
		end
	end

	assign in_ready = !buf_full;

	bdsp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign packet_sum  = out_data.sum;
	assign session_end = out_data.session_end;

endmodule
